// ===== src/ffia_pkg.sv =====
`default_nettype none

package ffia_pkg;

    // Sizes of the tables.
    localparam int NUM_LEVELS       = 16;
    localparam int MAX_EVENTS       = 1024;
    localparam int STACK_DEPTH      = 4;
    localparam int MAX_RESERVATIONS = 128;
    localparam int MAX_GROUPS       = 32;

    // Field and index widths.
    localparam int POS_W      = 11;
    localparam int LVL_IDX_W  = 4;
    localparam int LEVEL_W    = 5;
    localparam int DEPTH_W    = 2;
    localparam int HGT_W      = 3;
    localparam int STK_ADDR_W = LVL_IDX_W + DEPTH_W;
    localparam int FLUSH_W    = STK_ADDR_W + 1;
    localparam int RES_IDX_W  = 7;
    localparam int RES_CNT_W  = 8;
    localparam int GRP_IDX_W  = 5;
    localparam int GRP_CNT_W  = 6;
    localparam int KEY_W      = 16;
    localparam int NUM_W      = 5;
    localparam int KIND_W     = 2;

    // Event kinds.
    localparam logic [KIND_W-1:0] KIND_EXPLICIT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_IDENTITY = 2'd2;

    // End position of a start that is never closed.
    localparam logic [POS_W-1:0] OPEN_END = {POS_W{1'b1}};

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic [LVL_IDX_W-1:0] lvl;
        pos_t                 first;
        pos_t                 last;
    } resv_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        pos_t             first;
        pos_t             last;
    } grp_t;

    // Datapath operations, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_CLAIM,
        OP_PUSH,
        OP_POP,
        OP_RES_PAIR,
        OP_RES_POINT,
        OP_GRP_RD,
        OP_GRP_HIT,
        OP_GRP_NEXT,
        OP_GRP_NEW,
        OP_FL_INIT,
        OP_FL_RD,
        OP_FL_RES,
        OP_FL_SKIP,
        OP_EMPTY_OUT,
        OP_G_RD,
        OP_G_LATCH,
        OP_R_RD,
        OP_R_CMP,
        OP_J_INIT,
        OP_J_RD,
        OP_J_CMP,
        OP_G_EMIT,
        OP_CLEAR
    } dp_op_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_finish;
        logic ev_full;
        logic explicit_ok;
        logic identity;
        logic is_open;
        logic can_pop;
        logic grp_scan_end;
        logic key_match;
        logic flush_end;
        logic flush_live;
        logic no_groups;
        logic res_scan_end;
        logic prior_scan_end;
        logic last_group;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/ffia_evt_if.sv =====
`default_nettype none

interface ffia_evt_if import ffia_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               command;
    logic [KIND_W-1:0]  number_kind;
    logic [LEVEL_W-1:0] level;
    logic [KEY_W-1:0]   identity_key;
    logic               opens;
    logic               closes;

    modport source (
        output valid, command, number_kind, level, identity_key, opens, closes,
        input  ready
    );
    modport sink (
        input  valid, command, number_kind, level, identity_key, opens, closes,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/ffia_res_if.sv =====
`default_nettype none

interface ffia_res_if import ffia_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] group_key;
    logic [NUM_W-1:0] assigned_number;
    logic             group_valid;
    logic             exhausted;
    logic             overflow;
    logic             last;

    modport source (
        output valid, group_key, assigned_number, group_valid, exhausted, overflow, last,
        input  ready
    );
    modport sink (
        input  valid, group_key, assigned_number, group_valid, exhausted, overflow, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/first_fit_interval_number_allocator.sv =====
// First-fit interval number allocator. Events of one spanner class arrive as transactions on
// the events channel, one position each; a finish transaction flushes still-open starts into
// the reservation table, then gives each identity group, in order of first appearance, the
// lowest number from 1 to 16 free over its extent, one results transaction per group (or a
// single transaction with group_valid low when there are no groups), after which the class
// state is cleared. One item is handled at a time. A load of an identity event searches the
// group table by key, comparing its entries one at a time. A finish sweeps the stacks for
// open starts, then for each group scans the reservations and the earlier groups, since the
// reservation and group tables are memories read one entry at a time; results also wait for
// the output register.
`default_nettype none

module first_fit_interval_number_allocator import ffia_pkg::*; (
    input wire logic   clk,
    input wire logic   rst_n,
    ffia_evt_if.sink   events,
    ffia_res_if.source results
);

    dp_op_t   op;
    dp_stat_t stat;

    ffia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (events.valid),
        .evt_ready (events.ready),
        .stat      (stat),
        .op        (op)
    );

    ffia_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op),
        .stat    (stat),
        .events  (events),
        .results (results)
    );

endmodule

`default_nettype wire

// ===== src/ffia_ctrl.sv =====
`default_nettype none

module ffia_ctrl import ffia_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     evt_valid,
    output logic          evt_ready,
    input  wire dp_stat_t stat,
    output dp_op_t        op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH,
        S_POP,
        S_PAIR,
        S_POINT,
        S_GRP_RD,
        S_GRP_CMP,
        S_FL_RD,
        S_FL_RES,
        S_EMPTY,
        S_G_RD,
        S_G_LATCH,
        S_R_RD,
        S_R_CMP,
        S_J_RD
    } state_t;

    // The prior-group compare shares the state space through a flag.
    state_t state_reg, state_next;
    logic   jcmp_reg, jcmp_next;
    logic   clear_reg, clear_next;

    assign evt_ready = (state_reg == S_IDLE) && !clear_reg;

    // Next state and the operation for the datapath.
    always_comb
    begin
        state_next = state_reg;
        jcmp_next  = 1'b0;
        clear_next = 1'b0;
        op         = OP_NONE;
        if (clear_reg)
        begin
            op         = OP_CLEAR;
            state_next = S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (evt_valid)
                    begin
                        op         = OP_CAPTURE;
                        state_next = S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    if (stat.is_finish)
                    begin
                        op         = OP_FL_INIT;
                        state_next = S_FL_RD;
                    end
                    else
                    begin
                        op = OP_CLAIM;
                        if (stat.ev_full)
                            state_next = S_IDLE;
                        else if (stat.explicit_ok)
                        begin
                            if (stat.is_open)
                                state_next = S_PUSH;
                            else if (stat.can_pop)
                                state_next = S_POP;
                            else
                                state_next = S_POINT;
                        end
                        else if (stat.identity)
                            state_next = S_GRP_RD;
                        else
                            state_next = S_IDLE;
                    end
                end
                S_PUSH:
                begin
                    op         = OP_PUSH;
                    state_next = S_IDLE;
                end
                S_POP:
                begin
                    op         = OP_POP;
                    state_next = S_PAIR;
                end
                S_PAIR:
                begin
                    op         = OP_RES_PAIR;
                    state_next = S_IDLE;
                end
                S_POINT:
                begin
                    op         = OP_RES_POINT;
                    state_next = S_IDLE;
                end
                S_GRP_RD:
                begin
                    if (stat.grp_scan_end)
                    begin
                        op         = OP_GRP_NEW;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        op         = OP_GRP_RD;
                        state_next = S_GRP_CMP;
                    end
                end
                S_GRP_CMP:
                begin
                    if (stat.key_match)
                    begin
                        op         = OP_GRP_HIT;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        op         = OP_GRP_NEXT;
                        state_next = S_GRP_RD;
                    end
                end
                S_FL_RD:
                begin
                    if (stat.flush_end)
                        state_next = stat.no_groups ? S_EMPTY : S_G_RD;
                    else if (stat.flush_live)
                    begin
                        op         = OP_FL_RD;
                        state_next = S_FL_RES;
                    end
                    else
                        op = OP_FL_SKIP;
                end
                S_FL_RES:
                begin
                    op         = OP_FL_RES;
                    state_next = S_FL_RD;
                end
                S_EMPTY:
                begin
                    if (stat.out_free)
                    begin
                        op         = OP_EMPTY_OUT;
                        clear_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                S_G_RD:
                begin
                    op         = OP_G_RD;
                    state_next = S_G_LATCH;
                end
                S_G_LATCH:
                begin
                    op         = OP_G_LATCH;
                    state_next = S_R_RD;
                end
                S_R_RD:
                begin
                    if (stat.res_scan_end)
                    begin
                        op         = OP_J_INIT;
                        state_next = S_J_RD;
                    end
                    else
                    begin
                        op         = OP_R_RD;
                        state_next = S_R_CMP;
                    end
                end
                S_R_CMP:
                begin
                    op         = OP_R_CMP;
                    state_next = S_R_RD;
                end
                S_J_RD:
                begin
                    if (jcmp_reg)
                        op = OP_J_CMP;
                    else if (!stat.prior_scan_end)
                    begin
                        op        = OP_J_RD;
                        jcmp_next = 1'b1;
                    end
                    else if (stat.out_free)
                    begin
                        op = OP_G_EMIT;
                        if (stat.last_group)
                        begin
                            clear_next = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                            state_next = S_G_RD;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            jcmp_reg  <= 1'b0;
            clear_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            jcmp_reg  <= jcmp_next;
            clear_reg <= clear_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ffia_dp.sv =====
`default_nettype none

module ffia_dp import ffia_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire dp_op_t op,
    output dp_stat_t    stat,
    ffia_evt_if.sink    events,
    ffia_res_if.source  results
);

    // Captured transaction fields.
    logic               cmd_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [LEVEL_W-1:0] lvl_reg;
    logic [KEY_W-1:0]   key_reg;
    logic               opens_reg;
    logic               closes_reg;

    // Class state.
    logic [POS_W-1:0]     event_count_reg;
    logic [HGT_W-1:0]     heights_reg [NUM_LEVELS];
    logic [RES_CNT_W-1:0] res_count_reg;
    logic [GRP_CNT_W-1:0] grp_count_reg;
    logic                 ovf_reg;

    // Working registers.
    pos_t                  pos_reg;
    logic [RES_CNT_W-1:0]  idx_reg;
    logic [FLUSH_W-1:0]    sidx_reg;
    logic [GRP_CNT_W-1:0]  g_reg;
    grp_t                  cur_reg;
    logic [NUM_LEVELS-1:0] mask_reg;

    // Memories and their registered read data.
    pos_t             stk_mem [NUM_LEVELS*STACK_DEPTH];
    resv_t            res_mem [MAX_RESERVATIONS];
    grp_t             grp_mem [MAX_GROUPS];
    logic [NUM_W-1:0] asg_mem [MAX_GROUPS];
    pos_t             stk_q;
    resv_t            res_q;
    grp_t             grp_q;
    logic [NUM_W-1:0] asg_q;

    // Output register.
    logic             out_valid_reg;
    logic [KEY_W-1:0] out_key_reg;
    logic [NUM_W-1:0] out_num_reg;
    logic             out_gvalid_reg;
    logic             out_exh_reg;
    logic             out_ovf_reg;
    logic             out_last_reg;

    logic [LEVEL_W-1:0]    lvl_m1;
    logic [LVL_IDX_W-1:0]  li;
    logic [HGT_W-1:0]      hgt;
    logic [HGT_W-1:0]      hgt_m1;
    logic                  stack_full;
    logic                  res_full;
    logic                  grp_full;
    logic [STK_ADDR_W-1:0] stk_rd_addr;
    logic [GRP_IDX_W-1:0]  grp_rd_addr;
    logic                  res_wr;
    resv_t                 res_wr_data;
    logic                  res_meet;
    logic                  prior_meet;
    logic [NUM_W-1:0]      asg_m1;
    logic [NUM_W-1:0]      chosen;
    logic [GRP_CNT_W-1:0]  g_p1;

    // Decode of the captured event.
    always_comb
    begin
        lvl_m1     = lvl_reg - LEVEL_W'(1);
        li         = lvl_m1[LVL_IDX_W-1:0];
        hgt        = heights_reg[li];
        hgt_m1     = hgt - HGT_W'(1);
        stack_full = hgt >= HGT_W'(STACK_DEPTH);
        res_full   = res_count_reg == RES_CNT_W'(MAX_RESERVATIONS);
        grp_full   = grp_count_reg == GRP_CNT_W'(MAX_GROUPS);
        g_p1       = g_reg + GRP_CNT_W'(1);
    end

    // Overlap tests against the current group's extent.
    assign res_meet   = (res_q.first <= cur_reg.last) && (cur_reg.first <= res_q.last);
    assign prior_meet = (asg_q != '0) && (grp_q.first <= cur_reg.last) &&
                        (cur_reg.first <= grp_q.last);
    assign asg_m1     = asg_q - NUM_W'(1);

    // Lowest number whose bit is still clear, zero when all are taken.
    always_comb
    begin
        chosen = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (!mask_reg[i])
                chosen = NUM_W'(i + 1);
        end
    end

    // Status for the controller.
    always_comb
    begin
        stat.is_finish      = cmd_reg;
        stat.ev_full        = event_count_reg == POS_W'(MAX_EVENTS);
        stat.explicit_ok    = (kind_reg == KIND_EXPLICIT) && (lvl_reg != '0) &&
                              (lvl_reg <= LEVEL_W'(NUM_LEVELS));
        stat.identity       = kind_reg == KIND_IDENTITY;
        stat.is_open        = opens_reg;
        stat.can_pop        = closes_reg && (hgt != '0);
        stat.grp_scan_end   = idx_reg == RES_CNT_W'(grp_count_reg);
        stat.key_match      = grp_q.key == key_reg;
        stat.flush_end      = sidx_reg[FLUSH_W-1];
        stat.flush_live     = HGT_W'(sidx_reg[DEPTH_W-1:0]) <
                              heights_reg[sidx_reg[STK_ADDR_W-1:DEPTH_W]];
        stat.no_groups      = grp_count_reg == '0;
        stat.res_scan_end   = idx_reg == res_count_reg;
        stat.prior_scan_end = idx_reg == RES_CNT_W'(g_reg);
        stat.last_group     = g_p1 == grp_count_reg;
        stat.out_free       = !out_valid_reg;
    end

    // Reservation write request.
    always_comb
    begin
        res_wr      = 1'b0;
        res_wr_data = '0;
        case (op)
            OP_RES_PAIR:
            begin
                res_wr      = 1'b1;
                res_wr_data = '{lvl: li, first: stk_q, last: pos_reg};
            end
            OP_RES_POINT:
            begin
                res_wr      = 1'b1;
                res_wr_data = '{lvl: li, first: pos_reg, last: pos_reg};
            end
            OP_FL_RES:
            begin
                res_wr      = 1'b1;
                res_wr_data = '{lvl: sidx_reg[STK_ADDR_W-1:DEPTH_W], first: stk_q,
                                last: OPEN_END};
            end
            default:
            begin
                res_wr = 1'b0;
            end
        endcase
    end

    // Read addresses.
    assign stk_rd_addr = (op == OP_POP) ? {li, hgt_m1[DEPTH_W-1:0]}
                                        : sidx_reg[STK_ADDR_W-1:0];
    assign grp_rd_addr = (op == OP_G_RD) ? g_reg[GRP_IDX_W-1:0]
                                         : idx_reg[GRP_IDX_W-1:0];

    // Start stack memory.
    always_ff @(posedge clk)
    begin
        if (op == OP_PUSH && !stack_full)
            stk_mem[{li, hgt[DEPTH_W-1:0]}] <= pos_reg;
        if (op == OP_POP || op == OP_FL_RD)
            stk_q <= stk_mem[stk_rd_addr];
    end

    // Reservation memory.
    always_ff @(posedge clk)
    begin
        if (res_wr && !res_full)
            res_mem[res_count_reg[RES_IDX_W-1:0]] <= res_wr_data;
        if (op == OP_R_RD)
            res_q <= res_mem[idx_reg[RES_IDX_W-1:0]];
    end

    // Group table memory.
    always_ff @(posedge clk)
    begin
        if (op == OP_GRP_HIT)
            grp_mem[idx_reg[GRP_IDX_W-1:0]] <= '{key: key_reg, first: grp_q.first,
                                                 last: pos_reg};
        else if (op == OP_GRP_NEW && !grp_full)
            grp_mem[grp_count_reg[GRP_IDX_W-1:0]] <= '{key: key_reg, first: pos_reg,
                                                       last: pos_reg};
        if (op == OP_GRP_RD || op == OP_G_RD || op == OP_J_RD)
            grp_q <= grp_mem[grp_rd_addr];
    end

    // Assigned number memory.
    always_ff @(posedge clk)
    begin
        if (op == OP_G_EMIT)
            asg_mem[g_reg[GRP_IDX_W-1:0]] <= chosen;
        if (op == OP_J_RD)
            asg_q <= asg_mem[idx_reg[GRP_IDX_W-1:0]];
    end

    // Captured fields and working payload.
    always_ff @(posedge clk)
    begin
        if (op == OP_CAPTURE)
        begin
            cmd_reg    <= events.command;
            kind_reg   <= events.number_kind;
            lvl_reg    <= events.level;
            key_reg    <= events.identity_key;
            opens_reg  <= events.opens;
            closes_reg <= events.closes;
        end
        if (op == OP_CLAIM)
            pos_reg <= event_count_reg;
        if (op == OP_G_LATCH)
            cur_reg <= grp_q;
        if (op == OP_G_RD)
            mask_reg <= '0;
        else if (op == OP_R_CMP && res_meet)
            mask_reg[res_q.lvl] <= 1'b1;
        else if (op == OP_J_CMP && prior_meet)
            mask_reg[asg_m1[LVL_IDX_W-1:0]] <= 1'b1;
        if (op == OP_EMPTY_OUT)
        begin
            out_key_reg    <= '0;
            out_num_reg    <= '0;
            out_gvalid_reg <= 1'b0;
            out_exh_reg    <= 1'b0;
            out_ovf_reg    <= ovf_reg;
            out_last_reg   <= 1'b1;
        end
        else if (op == OP_G_EMIT)
        begin
            out_key_reg    <= cur_reg.key;
            out_num_reg    <= chosen;
            out_gvalid_reg <= 1'b1;
            out_exh_reg    <= chosen == '0;
            out_ovf_reg    <= ovf_reg;
            out_last_reg   <= stat.last_group;
        end
    end

    // Counters, indices, stack heights, the output valid flag and the overflow flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_count_reg <= '0;
            res_count_reg   <= '0;
            grp_count_reg   <= '0;
            ovf_reg         <= 1'b0;
            idx_reg         <= '0;
            sidx_reg        <= '0;
            g_reg           <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++)
                heights_reg[i] <= '0;
        end
        else
        begin
            if (op == OP_EMPTY_OUT || op == OP_G_EMIT)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
            if (res_wr)
            begin
                if (res_full)
                    ovf_reg <= 1'b1;
                else
                    res_count_reg <= res_count_reg + RES_CNT_W'(1);
            end
            case (op)
                OP_CLAIM:
                begin
                    idx_reg <= '0;
                    if (stat.ev_full)
                        ovf_reg <= 1'b1;
                    else
                        event_count_reg <= event_count_reg + POS_W'(1);
                end
                OP_PUSH:
                begin
                    if (stack_full)
                        ovf_reg <= 1'b1;
                    else
                        heights_reg[li] <= hgt + HGT_W'(1);
                end
                OP_POP:
                begin
                    heights_reg[li] <= hgt_m1;
                end
                OP_GRP_NEXT, OP_R_CMP, OP_J_CMP:
                begin
                    idx_reg <= idx_reg + RES_CNT_W'(1);
                end
                OP_GRP_NEW:
                begin
                    if (grp_full)
                        ovf_reg <= 1'b1;
                    else
                        grp_count_reg <= grp_count_reg + GRP_CNT_W'(1);
                end
                OP_FL_INIT:
                begin
                    sidx_reg <= '0;
                    g_reg    <= '0;
                end
                OP_FL_RES, OP_FL_SKIP:
                begin
                    sidx_reg <= sidx_reg + FLUSH_W'(1);
                end
                OP_G_RD, OP_J_INIT:
                begin
                    idx_reg <= '0;
                end
                OP_G_EMIT:
                begin
                    g_reg <= g_p1;
                end
                OP_CLEAR:
                begin
                    event_count_reg <= '0;
                    res_count_reg   <= '0;
                    grp_count_reg   <= '0;
                    ovf_reg         <= 1'b0;
                    for (int i = 0; i < NUM_LEVELS; i++)
                        heights_reg[i] <= '0;
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // Output channel.
    assign results.valid           = out_valid_reg;
    assign results.group_key       = out_key_reg;
    assign results.assigned_number = out_num_reg;
    assign results.group_valid     = out_gvalid_reg;
    assign results.exhausted       = out_exh_reg;
    assign results.overflow        = out_ovf_reg;
    assign results.last            = out_last_reg;

`ifndef SYNTH
    // A new result is only written into an empty output register.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_G_EMIT || op == OP_EMPTY_OUT) |-> !out_valid_reg)
        else $error("result written over a pending transaction");

    // Table fill counts stay within their tables.
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        res_count_reg <= RES_CNT_W'(MAX_RESERVATIONS) &&
        grp_count_reg <= GRP_CNT_W'(MAX_GROUPS) &&
        event_count_reg <= POS_W'(MAX_EVENTS))
        else $error("table count beyond its depth");

    // Finishing a class leaves every count and the overflow flag cleared.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_CLEAR |=> (event_count_reg == '0 && res_count_reg == '0 &&
                            grp_count_reg == '0 && !ovf_reg))
        else $error("class state not cleared after finish");

    // Groups are only emitted while some remain.
    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_G_EMIT |-> g_reg < grp_count_reg)
        else $error("emitting a group that does not exist");
`endif

endmodule

`default_nettype wire

// ===== dv/ffia_tb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Expected result of one finish step and the transaction type, shared by the stimulus and the checker.
package ffia_tb_pkg;
    import ffia_pkg::*;

    typedef struct {
        logic [KEY_W-1:0] group_key;
        logic [NUM_W-1:0] assigned_number;
        logic             group_valid;
        logic             exhausted;
        logic             overflow;
        logic             last;
    } group_result_t;

    typedef struct {
        logic               command;
        logic [KIND_W-1:0]  number_kind;
        logic [LEVEL_W-1:0] level;
        logic [KEY_W-1:0]   identity_key;
        logic               opens;
        logic               closes;
    } spanner_event_t;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
endpackage

`default_nettype wire

// ===== dv/first_fit_interval_number_allocator_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none

module first_fit_interval_number_allocator_tb;
    import ffia_pkg::*;
    import ffia_tb_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic clk;
    logic rst_n;

    ffia_evt_if events ();
    ffia_res_if results ();

    first_fit_interval_number_allocator u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .events  (events.sink),
        .results (results.source)
    );

    // Allocator shadow state.
    int unsigned   sh_event_count;
    int unsigned   sh_stack [NUM_LEVELS][STACK_DEPTH];
    int unsigned   sh_height [NUM_LEVELS];
    int unsigned   sh_res_lvl [$];
    int unsigned   sh_res_first [$];
    int unsigned   sh_res_last [$];
    logic [KEY_W-1:0] sh_grp_key [$];
    int unsigned   sh_grp_first [$];
    int unsigned   sh_grp_last [$];
    bit            sh_overflow;

    spanner_event_t pending_events [$];
    group_result_t  expected_groups [$];

    int  sender_idle_pct;
    int  receiver_idle_pct;
    bit  hold_sender;
    bit  evt_taken;
    int  mismatches;
    int  results_seen;
    int  events_sent;
    int  finishes_sent;
    int  cycle_count;
    bit  timed_out;

    function automatic bit spans_meet(int unsigned af, int unsigned al,
                                      int unsigned bf, int unsigned bl);
        return af <= bl && bf <= al;
    endfunction

    function automatic void clear_class();
        sh_event_count = 0;
        foreach (sh_height[i]) sh_height[i] = 0;
        sh_res_lvl.delete();
        sh_res_first.delete();
        sh_res_last.delete();
        sh_grp_key.delete();
        sh_grp_first.delete();
        sh_grp_last.delete();
        sh_overflow = 0;
    endfunction

    function automatic void add_reservation(int unsigned lvl, int unsigned f, int unsigned l);
        if (sh_res_lvl.size() >= MAX_RESERVATIONS) begin
            sh_overflow = 1;
            return;
        end
        sh_res_lvl   = {sh_res_lvl, lvl};
        sh_res_first = {sh_res_first, f};
        sh_res_last  = {sh_res_last, l};
    endfunction

    // Track one load and, on finish, queue the numbers each group should receive.
    function automatic void predict_allocation(spanner_event_t ev);
        int unsigned pos;
        int unsigned li;
        int unsigned chosen;
        int unsigned assigned [$];
        bit free_num;
        bit found;
        group_result_t r;
        if (ev.command == CMD_LOAD) begin
            if (sh_event_count >= MAX_EVENTS) begin
                sh_overflow = 1;
                return;
            end
            pos = sh_event_count;
            sh_event_count = sh_event_count + 1;
            if (ev.number_kind == KIND_EXPLICIT) begin
                if (ev.level < 1 || ev.level > NUM_LEVELS) return;
                li = ev.level - 1;
                if (ev.opens) begin
                    if (sh_height[li] >= STACK_DEPTH) sh_overflow = 1;
                    else begin
                        sh_stack[li][sh_height[li]] = pos;
                        sh_height[li] = sh_height[li] + 1;
                    end
                end else if (ev.closes && sh_height[li] > 0) begin
                    sh_height[li] = sh_height[li] - 1;
                    add_reservation(ev.level, sh_stack[li][sh_height[li]], pos);
                end else begin
                    add_reservation(ev.level, pos, pos);
                end
            end else if (ev.number_kind == KIND_IDENTITY) begin
                found = 0;
                foreach (sh_grp_key[i]) begin
                    if (!found && sh_grp_key[i] == ev.identity_key) begin
                        sh_grp_last[i] = pos;
                        found = 1;
                    end
                end
                if (found) return;
                if (sh_grp_key.size() >= MAX_GROUPS) begin
                    sh_overflow = 1;
                    return;
                end
                sh_grp_key   = {sh_grp_key, ev.identity_key};
                sh_grp_first = {sh_grp_first, pos};
                sh_grp_last  = {sh_grp_last, pos};
            end
            return;
        end
        // Still-open starts reserve to the end of the class.
        for (int l = 0; l < NUM_LEVELS; l++)
            for (int d = 0; d < sh_height[l]; d++)
                add_reservation(l + 1, sh_stack[l][d], OPEN_END);
        if (sh_grp_key.size() == 0) begin
            r = '{group_key: '0, assigned_number: '0, group_valid: 0, exhausted: 0,
                  overflow: sh_overflow, last: 1};
            expected_groups = {expected_groups, r};
        end
        for (int g = 0; g < sh_grp_key.size(); g++) begin
            chosen = 0;
            for (int c = 1; c <= 16 && chosen == 0; c++) begin
                free_num = 1;
                foreach (sh_res_lvl[k])
                    if (sh_res_lvl[k] == c && spans_meet(sh_res_first[k], sh_res_last[k],
                                                         sh_grp_first[g], sh_grp_last[g]))
                        free_num = 0;
                for (int j = 0; j < g; j++)
                    if (assigned[j] == c && spans_meet(sh_grp_first[j], sh_grp_last[j],
                                                       sh_grp_first[g], sh_grp_last[g]))
                        free_num = 0;
                if (free_num) chosen = c;
            end
            assigned = {assigned, chosen};
            r = '{group_key: sh_grp_key[g], assigned_number: chosen[NUM_W-1:0],
                  group_valid: 1, exhausted: chosen == 0, overflow: sh_overflow,
                  last: g + 1 == sh_grp_key.size()};
            expected_groups = {expected_groups, r};
        end
        clear_class();
    endfunction

    function automatic spanner_event_t make_event(logic cmd, logic [KIND_W-1:0] kind,
                                                  logic [LEVEL_W-1:0] lvl,
                                                  logic [KEY_W-1:0] key, logic op, logic cl);
        spanner_event_t ev;
        ev = '{command: cmd, number_kind: kind, level: lvl, identity_key: key,
               opens: op, closes: cl};
        return ev;
    endfunction

    task automatic add_event(spanner_event_t ev);
        pending_events = {pending_events, ev};
    endtask

    task automatic add_finish();
        add_event(make_event(CMD_FINISH, KIND_W'($urandom_range(0, 3)),
                             LEVEL_W'($urandom_range(0, 31)), KEY_W'($urandom),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    endtask

    // A random class: random starts and stops on levels 1 to 4 mixed with groups and other events.
    task automatic add_random_class(int n_events);
        logic [KEY_W-1:0] keys [4];
        int sel;
        foreach (keys[i]) keys[i] = KEY_W'($urandom);
        for (int i = 0; i < n_events; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                add_event(make_event(CMD_LOAD, KIND_EXPLICIT, LEVEL_W'($urandom_range(1, 4)),
                                     KEY_W'($urandom), 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1))));
            else if (sel < 85)
                add_event(make_event(CMD_LOAD, KIND_IDENTITY, LEVEL_W'($urandom),
                                     keys[$urandom_range(0, 3)], 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1))));
            else
                add_event(make_event(CMD_LOAD, KIND_W'($urandom_range(0, 3)),
                                     LEVEL_W'($urandom_range(0, 31)), KEY_W'($urandom),
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        end
        add_finish();
    endtask

    // Clock and reset.
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
    end

    // Driver: presents queued transactions and a random results ready at the falling edge.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            events.valid        <= 0;
            events.command      <= 0;
            events.number_kind  <= 0;
            events.level        <= 0;
            events.identity_key <= 0;
            events.opens        <= 0;
            events.closes       <= 0;
            results.ready       <= 0;
        end
        else
        begin
            results.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            if (!events.valid || evt_taken)
            begin
                if (pending_events.size() > 0 && !hold_sender &&
                    $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    events.valid        <= 1;
                    events.command      <= pending_events[0].command;
                    events.number_kind  <= pending_events[0].number_kind;
                    events.level        <= pending_events[0].level;
                    events.identity_key <= pending_events[0].identity_key;
                    events.opens        <= pending_events[0].opens;
                    events.closes       <= pending_events[0].closes;
                    void'(pending_events.pop_front());
                end
                else
                    events.valid <= 0;
            end
        end
    end

    // Monitor: predicts on accepted inputs and checks accepted results.
    always @(posedge clk)
    begin
        spanner_event_t ev;
        group_result_t  exp_r;
        evt_taken = 0;
        if (rst_n)
        begin
            cycle_count++;
            if (events.valid && events.ready)
            begin
                evt_taken = 1;
                ev = make_event(events.command, events.number_kind, events.level,
                                events.identity_key, events.opens, events.closes);
                predict_allocation(ev);
                events_sent++;
                if (ev.command == CMD_FINISH) finishes_sent++;
            end
            if (results.valid && results.ready)
            begin
                results_seen++;
                if (expected_groups.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result key=%h num=%0d",
                                 results.group_key, results.assigned_number);
                end
                else
                begin
                    exp_r = expected_groups.pop_front();
                    if (results.group_key !== exp_r.group_key ||
                        results.assigned_number !== exp_r.assigned_number ||
                        results.group_valid !== exp_r.group_valid ||
                        results.exhausted !== exp_r.exhausted ||
                        results.overflow !== exp_r.overflow ||
                        results.last !== exp_r.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: result mismatch exp key=%h num=%0d gv=%b ex=%b ",
                                      "ov=%b last=%b got key=%h num=%0d gv=%b ex=%b ov=%b ",
                                      "last=%b"},
                                     exp_r.group_key, exp_r.assigned_number,
                                     exp_r.group_valid, exp_r.exhausted, exp_r.overflow,
                                     exp_r.last, results.group_key, results.assigned_number,
                                     results.group_valid, results.exhausted,
                                     results.overflow, results.last);
                    end
                end
            end
        end
    end

    // Run watchdog.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("ERROR: timeout after %0d cycles", cycle_count);
        $display("Test completed with failures");
        $finish;
    end

    task automatic drain_all();
        wait (pending_events.size() == 0);
        while (events.valid || expected_groups.size() != 0) @(posedge clk);
    endtask

    // Stimulus.
    initial
    begin
        clear_class();
        sender_idle_pct   = 32;
        receiver_idle_pct = 74;
        hold_sender = 0;
        // Directed: empty class, then one covering field extremes and special cases.
        add_finish();
        add_event(make_event(CMD_LOAD, KIND_EXPLICIT, 1, 16'h0000, 1, 0));
        add_event(make_event(CMD_LOAD, KIND_IDENTITY, 0, 16'hFFFF, 0, 0));
        add_event(make_event(CMD_LOAD, KIND_EXPLICIT, 1, 16'h0000, 0, 1));
        add_event(make_event(CMD_LOAD, KIND_EXPLICIT, 16, 16'h0000, 1, 1));
        add_event(make_event(CMD_LOAD, KIND_EXPLICIT, 2, 16'h0000, 0, 0));
        add_event(make_event(CMD_LOAD, KIND_EXPLICIT, 3, 16'h0000, 0, 1));
        add_event(make_event(CMD_LOAD, KIND_EXPLICIT, 0, 16'h0000, 1, 0));
        add_event(make_event(CMD_LOAD, KIND_EXPLICIT, 31, 16'h0000, 1, 0));
        add_event(make_event(CMD_LOAD, KIND_NONE, 5, 16'h1234, 1, 0));
        add_event(make_event(CMD_LOAD, KIND_SPARE, 5, 16'h1234, 0, 1));
        add_event(make_event(CMD_LOAD, KIND_IDENTITY, 31, 16'h0000, 1, 1));
        add_event(make_event(CMD_LOAD, KIND_IDENTITY, 0, 16'hFFFF, 0, 1));
        for (int i = 0; i < 5; i++)
            add_event(make_event(CMD_LOAD, KIND_EXPLICIT, 4, 16'h0000, 1, 0));
        add_finish();
        // Exhaustion: every level holds an open start inside the group's span, so all sixteen numbers are taken.
        add_event(make_event(CMD_LOAD, KIND_IDENTITY, 0, 16'hABCD, 0, 0));
        for (int l = 1; l <= 16; l++)
            add_event(make_event(CMD_LOAD, KIND_EXPLICIT, LEVEL_W'(l), 0, 1, 0));
        add_event(make_event(CMD_LOAD, KIND_IDENTITY, 0, 16'hABCD, 0, 0));
        add_event(make_event(CMD_LOAD, KIND_IDENTITY, 0, 16'h5555, 0, 0));
        add_finish();
        drain_all();
        // Group table overflow: 33 distinct keys.
        for (int i = 0; i < 33; i++)
            add_event(make_event(CMD_LOAD, KIND_IDENTITY, 0, KEY_W'(16'h100 + i), 0, 0));
        add_finish();
        add_random_class($urandom_range(6, 12));
        drain_all();
        // Pressure: hold off the sender until every result has come.
        hold_sender = 1;
        drain_all();
        hold_sender = 0;
        sender_idle_pct   = 74;
        receiver_idle_pct = 32;
        add_random_class($urandom_range(6, 12));
        drain_all();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        add_random_class($urandom_range(6, 12));
        drain_all();
        repeat (300) @(posedge clk);
        $display("Covered %0d transactions (%0d finishes) and checked %0d results.",
                 events_sent, finishes_sent, results_seen);
        if (mismatches == 0 && expected_groups.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

`default_nettype wire
